// ----- rtl/oahm_pkg.sv -----
// ----------------------------------------------------------------------------
// oahm_pkg
// Shared codes, field widths and hash constants of the hash map core.
// ----------------------------------------------------------------------------
package oahm_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int LIVE_W   = 11;
    localparam int MARK_W   = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DEAD  = 2'd2;

    localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int               MIX_SHIFT = 33;

endpackage

// ----- rtl/oahm_if.sv -----
// ----------------------------------------------------------------------------
// oahm_req_if / oahm_rsp_if
// Valid/ready channels for requests and responses of the hash map core.
// ----------------------------------------------------------------------------
interface oahm_req_if;
    import oahm_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [KEY_W-1:0]    lookup_key;
    logic [HANDLE_W-1:0] entry_value;

    modport source (output valid, operation, lookup_key, entry_value, input ready);
    modport sink   (input valid, operation, lookup_key, entry_value, output ready);
endinterface

interface oahm_rsp_if;
    import oahm_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_value;
    logic [SLOT_W-1:0]   slot_index;
    logic [LIVE_W-1:0]   live_count;

    modport source (output valid, status, found_value, slot_index, live_count, input ready);
    modport sink   (input valid, status, found_value, slot_index, live_count, output ready);
endinterface

// ----- rtl/oahm_ram.sv -----
// ----------------------------------------------------------------------------
// oahm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oahm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/oahm_hash.sv -----
// ----------------------------------------------------------------------------
// oahm_hash
// 64-bit fmix finalizer on one shared 32x32 multiplier, four steps per
// 64-bit product, two products per key.
// ----------------------------------------------------------------------------
module oahm_hash #(
    parameter int IDX_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [oahm_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [IDX_BITS-1:0]       hash
);
    import oahm_pkg::*;

    typedef enum logic [1:0] {
        H_IDLE = 2'b01,
        H_RUN  = 2'b10
    } hstate_t;

    hstate_t           state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic              round_reg, round_next;
    logic              done_reg, done_next;
    logic [KEY_W-1:0]  x_reg, x_next;
    logic [KEY_W-1:0]  acc_reg, acc_next;
    logic [KEY_W-1:0]  prod_reg, prod_next;
    logic [31:0]       mul_a, mul_b;
    logic [KEY_W-1:0]  coef;
    logic [KEY_W-1:0]  sum;

    assign coef = round_reg ? MIX_C2 : MIX_C1;
    assign sum  = acc_reg + {prod_reg[31:0], 32'd0};

    always_comb
    begin
        mul_a = x_reg[31:0];
        mul_b = coef[31:0];
        case (step_reg)
            2'd1:    mul_b = coef[63:32];
            2'd2:    mul_a = x_reg[63:32];
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        round_next = round_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    x_next     = key ^ (key >> MIX_SHIFT);
                    step_next  = 2'd0;
                    round_next = 1'b0;
                    state_next = H_RUN;
                end
            end
            H_RUN:
            begin
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd1:    acc_next = prod_reg;
                    2'd2:    acc_next = sum;
                    2'd3:
                    begin
                        x_next = sum ^ (sum >> MIX_SHIFT);
                        if (round_reg)
                        begin
                            done_next  = 1'b1;
                            state_next = H_IDLE;
                        end
                        round_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            step_reg  <= 2'd0;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign hash = x_reg[IDX_BITS-1:0];

endmodule

// ----- rtl/open_addressing_hash_map_core.sv -----
// ----------------------------------------------------------------------------
// open_addressing_hash_map_core
// Linear-probing hash table with tombstones, 64-bit keys to value handles.
// ----------------------------------------------------------------------------
// After reset the core sweeps the mark store to empty, one slot per cycle,
// with req.ready low. A request then runs through the fmix hash (eight steps
// on one shared 32x32 multiplier and a hand-off), a read and a compare state
// on the slot RAMs for each probed slot, and a write state when it writes a
// slot. An insert rejected on load goes straight to the finish state. One
// request is in flight at a time; the response sits in an output register so
// the next request can be accepted while it waits.
module open_addressing_hash_map_core #(
    parameter int TABLE_SLOTS = 1024,
    parameter int VALUE_BITS  = 32
) (
    input logic        clk,
    input logic        rst_n,
    oahm_req_if.sink   req,
    oahm_rsp_if.source rsp
);
    import oahm_pkg::*;

    localparam int IW    = $clog2(TABLE_SLOTS);
    localparam int CW    = IW + 1;
    localparam int LIMIT = (TABLE_SLOTS * 7 + 9) / 10;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [IW-1:0]        clr_reg, clr_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [IW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [IW-1:0]        dead_reg, dead_next;
    logic                 have_dead_reg, have_dead_next;
    logic [STATUS_W-1:0]  st_reg, st_next;
    logic [HANDLE_W-1:0]  found_reg, found_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic [IW-1:0]        wr_addr_reg, wr_addr_next;
    logic                 wr_ins_reg, wr_ins_next;
    logic [CW-1:0]        occ_reg, occ_next;
    logic [CW-1:0]        tomb_reg, tomb_next;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [HANDLE_W-1:0]  out_found_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [LIVE_W-1:0]    out_live_reg;
    logic                 out_load;

    logic                 hash_start;
    logic                 hash_done;
    logic [IW-1:0]        hash_idx;

    logic                 do_hit, do_miss, miss_has_tgt;
    logic [IW-1:0]        miss_tgt;
    logic [CW:0]          used;

    logic [KEY_W-1:0]     key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic [MARK_W-1:0]    mark_rd;
    logic                 mark_we, data_we;
    logic [IW-1:0]        mark_waddr;
    logic [MARK_W-1:0]    mark_wdata;
    logic [VALUE_BITS-1:0] val_wdata;

    oahm_hash #(.IDX_BITS(IW)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_next),
        .done  (hash_done),
        .hash  (hash_idx)
    );

    assign data_we    = (state_reg == S_WRITE);
    assign mark_we    = (state_reg == S_CLEAR) || data_we;
    assign mark_waddr = (state_reg == S_CLEAR) ? clr_reg : wr_addr_reg;
    assign mark_wdata = (state_reg == S_CLEAR) ? MARK_EMPTY
                      : (wr_ins_reg ? MARK_LIVE : MARK_DEAD);
    assign val_wdata  = wr_ins_reg ? val_reg : '0;

    oahm_ram #(.WIDTH(MARK_W), .DEPTH(TABLE_SLOTS)) u_marks (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (pos_reg),
        .rdata (mark_rd)
    );

    oahm_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_keys (
        .clk   (clk),
        .we    (data_we && wr_ins_reg),
        .waddr (wr_addr_reg),
        .wdata (key_reg),
        .raddr (pos_reg),
        .rdata (key_rd)
    );

    oahm_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_SLOTS)) u_values (
        .clk   (clk),
        .we    (data_we),
        .waddr (wr_addr_reg),
        .wdata (val_wdata),
        .raddr (pos_reg),
        .rdata (val_rd)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign used      = {1'b0, occ_reg} + {1'b0, tomb_reg} + (CW + 1)'(1);
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        dead_next      = dead_reg;
        have_dead_next = have_dead_reg;
        st_next        = st_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        wr_addr_next   = wr_addr_reg;
        wr_ins_next    = wr_ins_reg;
        occ_next       = occ_reg;
        tomb_next      = tomb_reg;
        hash_start     = 1'b0;
        do_hit         = 1'b0;
        do_miss        = 1'b0;
        miss_has_tgt   = 1'b0;
        miss_tgt       = dead_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    key_next   = req.lookup_key;
                    val_next   = VALUE_BITS'(req.entry_value);
                    st_next    = ST_MISSING;
                    found_next = '0;
                    slot_next  = '0;
                    if (req.operation == OP_INSERT && used >= (CW + 1)'(LIMIT))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    pos_next       = hash_idx;
                    cnt_next       = '0;
                    have_dead_next = 1'b0;
                    dead_next      = '0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                if (cnt_reg == CW'(TABLE_SLOTS))
                begin
                    do_miss      = 1'b1;
                    miss_has_tgt = have_dead_reg;
                    miss_tgt     = dead_reg;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (mark_rd)
                    MARK_EMPTY:
                    begin
                        do_miss      = 1'b1;
                        miss_has_tgt = 1'b1;
                        miss_tgt     = have_dead_reg ? dead_reg : pos_reg;
                    end
                    MARK_LIVE:
                    begin
                        if (key_rd == key_reg)
                        begin
                            do_hit = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!have_dead_reg)
                        begin
                            have_dead_next = 1'b1;
                            dead_next      = pos_reg;
                        end
                    end
                endcase
                if (!do_hit && !do_miss)
                begin
                    pos_next   = pos_reg + IW'(1);
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                if (wr_ins_reg)
                begin
                    occ_next = occ_reg + CW'(1);
                    if (have_dead_reg && tomb_reg != '0)
                    begin
                        tomb_next = tomb_reg - CW'(1);
                    end
                end
                else
                begin
                    if (occ_reg != '0)
                    begin
                        occ_next = occ_reg - CW'(1);
                    end
                    tomb_next = tomb_reg + CW'(1);
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_hit)
        begin
            slot_next = pos_reg;
            case (op_reg)
                OP_INSERT:
                begin
                    st_next    = ST_DUPLICATE;
                    state_next = S_FIN;
                end
                OP_ERASE:
                begin
                    st_next      = ST_OK;
                    wr_addr_next = pos_reg;
                    wr_ins_next  = 1'b0;
                    state_next   = S_WRITE;
                end
                default:
                begin
                    st_next    = ST_OK;
                    found_next = HANDLE_W'(val_rd);
                    state_next = S_FIN;
                end
            endcase
        end

        if (do_miss)
        begin
            state_next = S_FIN;
            if (op_reg == OP_INSERT)
            begin
                if (miss_has_tgt)
                begin
                    st_next      = ST_OK;
                    slot_next    = miss_tgt;
                    wr_addr_next = miss_tgt;
                    wr_ins_next  = 1'b1;
                    state_next   = S_WRITE;
                end
                else
                begin
                    st_next = ST_FULL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            occ_reg   <= '0;
            tomb_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            occ_reg   <= occ_next;
            tomb_reg  <= tomb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        cnt_reg       <= cnt_next;
        dead_reg      <= dead_next;
        have_dead_reg <= have_dead_next;
        st_reg        <= st_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        wr_addr_reg   <= wr_addr_next;
        wr_ins_reg    <= wr_ins_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= st_reg;
            out_found_reg  <= found_reg;
            out_slot_reg   <= SLOT_W'(slot_reg);
            out_live_reg   <= LIVE_W'(occ_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_value = out_found_reg;
    assign rsp.slot_index  = out_slot_reg;
    assign rsp.live_count  = out_live_reg;

endmodule

// ----- dv/oahm_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oahm testbench channels
// Note: the request and response interfaces come from rtl/oahm_if.sv; this
// file holds the shared transaction types used by the testbench.
// ----------------------------------------------------------------------------
package oahm_tb_pkg;
    import oahm_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [KEY_W-1:0]    lookup_key;
        logic [HANDLE_W-1:0] entry_value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] found_value;
        logic [SLOT_W-1:0]   slot_index;
        logic [LIVE_W-1:0]   live_count;
    } response_t;
endpackage

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives lookups, inserts and erases into the hash map core through random
// valid/ready gaps and checks every response against a software hash table
// that hashes, probes and tracks tombstones the same way, or against a fixed row.
// ----------------------------------------------------------------------------
module tb;
    import oahm_pkg::*;
    import oahm_tb_pkg::*;

    localparam int SLOTS = 1024;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int MAX_LATENCY = 12 + 2 * SLOTS + 50;

    logic clk;
    logic rst_n;

    oahm_req_if req ();
    oahm_rsp_if rsp ();

    open_addressing_hash_map_core #(
        .TABLE_SLOTS(SLOTS),
        .VALUE_BITS (32)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    logic [KEY_W-1:0]    model_keys   [SLOTS];
    logic [HANDLE_W-1:0] model_values [SLOTS];
    logic [MARK_W-1:0]   model_marks  [SLOTS];
    int unsigned         model_live;
    int unsigned         model_dead;

    response_t    pending_responses [$];
    logic [KEY_W-1:0] known_keys [$];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           mismatches = 0;
    longint       cycle_count = 0;

    typedef struct {
        request_t  item;
        bit        has_expected;
        response_t expected;
    } stim_row_t;

    stim_row_t directed_rows [$];

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [KEY_W-1:0] fmix64(logic [KEY_W-1:0] x);
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_C1;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_C2;
        x = x ^ (x >> MIX_SHIFT);
        return x;
    endfunction

    function automatic bit walk_chain(logic [KEY_W-1:0] key, output int unsigned hit,
                                      output bit have_target);
        int unsigned      pos;
        int unsigned      dead_pos;
        bit               have_dead;
        logic [KEY_W-1:0] h;
        h = fmix64(key);
        pos = 32'(h[$clog2(SLOTS)-1:0]);
        dead_pos = 0;
        have_dead = 0;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (model_marks[pos] == MARK_EMPTY)
            begin
                hit = have_dead ? dead_pos : pos;
                have_target = 1;
                return 0;
            end
            if (model_marks[pos] == MARK_LIVE)
            begin
                if (model_keys[pos] == key)
                begin
                    hit = pos;
                    have_target = 1;
                    return 1;
                end
            end
            else if (!have_dead)
            begin
                have_dead = 1;
                dead_pos = pos;
            end
            pos = (pos + 1) & (SLOTS - 1);
        end
        hit = dead_pos;
        have_target = have_dead;
        return 0;
    endfunction

    function automatic response_t apply_request(request_t r);
        response_t   res;
        int unsigned pos;
        bit          have_target;
        bit          hit;
        res = '0;
        res.status = ST_MISSING;
        if (r.operation == OP_INSERT)
        begin
            if ((model_live + model_dead + 1) * 10 >= SLOTS * 7)
                res.status = ST_FULL;
            else
            begin
                hit = walk_chain(r.lookup_key, pos, have_target);
                if (hit)
                begin
                    res.status = ST_DUPLICATE;
                    res.slot_index = SLOT_W'(pos);
                end
                else if (!have_target)
                    res.status = ST_FULL;
                else
                begin
                    if (model_marks[pos] != MARK_EMPTY && model_dead > 0)
                        model_dead--;
                    model_keys[pos] = r.lookup_key;
                    model_values[pos] = r.entry_value;
                    model_marks[pos] = MARK_LIVE;
                    model_live++;
                    res.status = ST_OK;
                    res.slot_index = SLOT_W'(pos);
                    known_keys.push_back(r.lookup_key);
                end
            end
        end
        else if (r.operation == OP_ERASE)
        begin
            hit = walk_chain(r.lookup_key, pos, have_target);
            if (hit)
            begin
                model_values[pos] = '0;
                model_marks[pos] = MARK_DEAD;
                if (model_live > 0)
                    model_live--;
                model_dead++;
                res.status = ST_OK;
                res.slot_index = SLOT_W'(pos);
            end
        end
        else
        begin
            hit = walk_chain(r.lookup_key, pos, have_target);
            if (hit)
            begin
                res.status = ST_OK;
                res.found_value = model_values[pos];
                res.slot_index = SLOT_W'(pos);
            end
        end
        res.live_count = LIVE_W'(model_live);
        return res;
    endfunction

    task automatic send_request(request_t r, bit has_expected, response_t fixed);
        response_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.operation   <= r.operation;
        req.lookup_key  <= r.lookup_key;
        req.entry_value <= r.entry_value;
        do
            @(posedge clk);
        while (!req.ready);
        res = apply_request(r);
        if (has_expected && res != fixed)
            $display("directed row disagrees with predictor: %h vs %h", fixed, res);
        pending_responses.push_back(has_expected ? fixed : res);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (known_keys.size() > 0 && $urandom_range(99) < 60)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        if ($urandom_range(3) == 0)
            return {$urandom_range(63), $urandom_range(63)};
        return {$urandom, $urandom};
    endfunction

    task automatic send_random(int count);
        request_t r;
        int       pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                r.operation = OP_INSERT;
            else if (pick < 70)
                r.operation = OP_LOOKUP;
            else if (pick < 97)
                r.operation = OP_ERASE;
            else
                r.operation = 2'd3;
            r.lookup_key  = pick_key();
            r.entry_value = $urandom;
            send_request(r, 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_responses.size() > 0)
            @(posedge clk);
    endtask

    function automatic void add_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                    logic [HANDLE_W-1:0] val, bit fixed,
                                    logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] fv,
                                    logic [LIVE_W-1:0] live);
        stim_row_t row;
        row.item = '{operation: op, lookup_key: key, entry_value: val};
        row.has_expected = fixed;
        row.expected = '{status: st, found_value: fv, slot_index: '0, live_count: live};
        directed_rows.push_back(row);
    endfunction

    always @(posedge clk)
    begin
        response_t got;
        response_t want;
        if (rsp.valid && rsp.ready)
        begin
            got = '{status: rsp.status, found_value: rsp.found_value,
                    slot_index: rsp.slot_index, live_count: rsp.live_count};
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", got);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_LOOKUP;
        req.lookup_key = '0;
        req.entry_value = '0;
        model_live = 0;
        model_dead = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            model_keys[i] = '0;
            model_values[i] = '0;
            model_marks[i] = MARK_EMPTY;
        end

        add_row(OP_LOOKUP, 64'd0, 32'd0, 1, ST_MISSING, 32'd0, 11'd0);
        add_row(OP_ERASE, '1, 32'd0, 1, ST_MISSING, 32'd0, 11'd0);
        add_row(OP_INSERT, 64'd0, 32'd0, 0, ST_OK, 32'd0, 11'd1);
        add_row(OP_INSERT, '1, '1, 0, ST_OK, 32'd0, 11'd2);
        add_row(OP_INSERT, '1, 32'h1234, 0, ST_DUPLICATE, 32'd0, 11'd2);
        add_row(OP_LOOKUP, '1, 32'd0, 0, ST_OK, 32'd0, 11'd2);
        add_row(OP_LOOKUP, 64'd0, 32'd0, 0, ST_OK, 32'd0, 11'd2);
        add_row(2'd3, '1, '1, 0, ST_OK, 32'd0, 11'd2);
        add_row(OP_ERASE, '1, 32'd0, 0, ST_OK, 32'd0, 11'd1);
        add_row(OP_LOOKUP, '1, 32'd0, 1, ST_MISSING, 32'd0, 11'd1);
        add_row(OP_ERASE, '1, 32'd0, 1, ST_MISSING, 32'd0, 11'd1);
        add_row(OP_INSERT, '1, 32'hAAAA5555, 0, ST_OK, 32'd0, 11'd2);
        add_row(OP_INSERT, 64'h8000000000000000, 32'h80000000, 0, ST_OK, 32'd0, 11'd3);
        add_row(OP_LOOKUP, 64'h8000000000000000, 32'd0, 0, ST_OK, 32'd0, 11'd3);
        add_row(OP_ERASE, 64'd0, 32'd0, 0, ST_OK, 32'd0, 11'd2);
        add_row(OP_ERASE, '1, 32'd0, 0, ST_OK, 32'd0, 11'd1);
        add_row(OP_ERASE, 64'h8000000000000000, 32'd0, 0, ST_OK, 32'd0, 11'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 33;
        recv_idle_pct = 64;
        foreach (directed_rows[i])
            send_request(directed_rows[i].item, directed_rows[i].has_expected,
                         directed_rows[i].expected);

        // fill past the load limit so full rejections show up
        for (int i = 0; i < 760; i++)
            send_request('{operation: OP_INSERT, lookup_key: {$urandom, $urandom},
                           entry_value: $urandom}, 1'b0, '0);
        wait_drained();
        send_random(150);

        send_idle_pct = 64;
        recv_idle_pct = 33;
        send_random(150);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(150);

        wait_drained();
        repeat (MAX_LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_responses.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/oahm_pkg.sv
rtl/oahm_if.sv
rtl/oahm_ram.sv
rtl/oahm_hash.sv
rtl/open_addressing_hash_map_core.sv
dv/oahm_tb_if.sv
dv/tb.sv
